// ===== hw/rtl/attrbt_pkg.sv =====
// Shared types, constants and helper functions for the ATT read by type
// response parser. No dependencies.
`timescale 1ns / 1ps

package attrbt_pkg;

   // Largest PDU length accepted by the header check
   localparam int MAX_PDU_BYTES = 512;
   localparam logic [10:0] MAX_PDU_LEN = 11'(MAX_PDU_BYTES);

   localparam logic [9:0] MIN_PDU_LEN  = 10'd9;
   localparam logic [9:0] HEADER_BYTES = 10'd2;
   localparam logic [9:0] POS_OPCODE   = 10'd0;
   localparam logic [9:0] POS_SIZE     = 10'd1;
   localparam logic [9:0] POS_MAX      = 10'h3FF;

   localparam logic [7:0] OPCODE_RESET = 8'd9;

   localparam logic [4:0] ELEM_SIZE_NONE  = 5'd0;
   localparam logic [4:0] ELEM_SIZE_SHORT = 5'd7;
   localparam logic [4:0] ELEM_SIZE_LONG  = 5'd21;

   // Byte offsets inside one element
   localparam logic [4:0] OFF_START_LO   = 5'd0;
   localparam logic [4:0] OFF_START_HI   = 5'd1;
   localparam logic [4:0] OFF_PROPERTY   = 5'd2;
   localparam logic [4:0] OFF_VALUE_LO   = 5'd3;
   localparam logic [4:0] OFF_VALUE_HI   = 5'd4;
   localparam logic [4:0] UUID_OFF_SHORT = 5'd5;
   localparam logic [4:0] UUID_OFF_LONG  = 5'd17;

   localparam logic [6:0] COUNT_MAX = 7'd127;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OPCODE    = 2'd1;
   localparam logic [1:0] ERR_LENGTH    = 2'd2;
   localparam logic [1:0] ERR_ELEM_SIZE = 2'd3;

   localparam logic REC_ELEMENT = 1'b0;
   localparam logic REC_STATUS  = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [9:0] pdu_length;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        record_kind;
      logic [15:0] attr_handle;
      logic [7:0]  property_bits;
      logic [15:0] value_handle;
      logic [15:0] short_uuid;
      logic [6:0]  element_count;
      logic [15:0] next_start;
      logic [1:0]  error_code;
      logic        run_end;
   } rsp_type;

   // Up to two records come out of one byte: an element, then a status
   typedef struct packed {
      logic    elem_valid;
      rsp_type elem;
      logic    stat_valid;
      rsp_type stat;
   } emit_type;

   // 8 == 1 mod 7: fold octal digits
   function automatic logic div_by_7(input logic [9:0] v);
      logic [4:0] s;
      logic [3:0] f;
      s = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[9]);
      f = 4'(s[4:3]) + 4'(s[2:0]);
      return (f == 4'd0) || (f == 4'd7);
   endfunction

   // 4 == 1 mod 3: fold base-4 digits
   function automatic logic div_by_3(input logic [9:0] v);
      logic [3:0] s;
      logic [2:0] f;
      s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]) + 4'(v[9:8]);
      f = 3'(s[3:2]) + 3'(s[1:0]);
      return (f == 3'd0) || (f == 3'd3) || (f == 3'd6);
   endfunction

endpackage

// ===== hw/rtl/attrbt_parse.sv =====
// Per-byte PDU state and record generation for the read by type parser.
// Depends on attrbt_pkg.
`timescale 1ns / 1ps

module attrbt_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  attrbt_pkg::req_type item,
   input  logic [7:0]        expected_opcode,
   output attrbt_pkg::emit_type emit
);

   logic [9:0]  pos_ff, pos_in;
   logic [4:0]  size_ff, size_in;
   logic [4:0]  off_ff, off_in;
   logic [6:0]  done_ff, done_in;
   logic [1:0]  err_ff, err_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  prop_ff, prop_in;
   logic [15:0] value_ff, value_in;
   logic [7:0]  uuid_lo_ff, uuid_lo_in;
   logic [15:0] next_handle_ff, next_handle_in;

   logic [7:0]  b;
   logic [9:0]  len;
   logic [9:0]  body_len;
   logic [4:0]  uuid_off;
   logic [4:0]  off_next;
   logic        len_fits;
   logic [1:0]  stat_err;

   always_comb begin
      b              = item.data_byte;
      len            = item.pdu_length;
      body_len       = len - attrbt_pkg::HEADER_BYTES;
      pos_in         = pos_ff;
      size_in        = size_ff;
      off_in         = off_ff;
      done_in        = done_ff;
      err_in         = err_ff;
      start_in       = start_ff;
      prop_in        = prop_ff;
      value_in       = value_ff;
      uuid_lo_in     = uuid_lo_ff;
      next_handle_in = next_handle_ff;
      uuid_off       = (size_ff == attrbt_pkg::ELEM_SIZE_SHORT) ?
                       attrbt_pkg::UUID_OFF_SHORT : attrbt_pkg::UUID_OFF_LONG;
      off_next       = off_ff + 5'd1;
      emit           = '0;
      stat_err       = attrbt_pkg::ERR_NONE;

      len_fits = (len >= attrbt_pkg::MIN_PDU_LEN) &&
                 ({1'b0, len} <= attrbt_pkg::MAX_PDU_LEN) &&
                 attrbt_pkg::div_by_7(body_len) &&
                 ((b[4:0] == attrbt_pkg::ELEM_SIZE_SHORT) ||
                  attrbt_pkg::div_by_3(body_len));

      if (pos_ff == attrbt_pkg::POS_OPCODE) begin
         err_in = (b != expected_opcode) ? attrbt_pkg::ERR_OPCODE : attrbt_pkg::ERR_NONE;
      end else if (pos_ff == attrbt_pkg::POS_SIZE) begin
         if (err_ff == attrbt_pkg::ERR_NONE) begin
            if ((b != 8'(attrbt_pkg::ELEM_SIZE_SHORT)) &&
                (b != 8'(attrbt_pkg::ELEM_SIZE_LONG))) begin
               err_in = attrbt_pkg::ERR_ELEM_SIZE;
            end else if (!len_fits) begin
               err_in = attrbt_pkg::ERR_LENGTH;
            end else begin
               size_in = b[4:0];
            end
         end
      end else if ((err_ff == attrbt_pkg::ERR_NONE) &&
                   (size_ff != attrbt_pkg::ELEM_SIZE_NONE) && (pos_ff < len)) begin
         if (off_ff == attrbt_pkg::OFF_START_LO) begin
            start_in = {8'h00, b};
         end else if (off_ff == attrbt_pkg::OFF_START_HI) begin
            start_in = {b, start_ff[7:0]};
         end else if (off_ff == attrbt_pkg::OFF_PROPERTY) begin
            prop_in = b;
         end else if (off_ff == attrbt_pkg::OFF_VALUE_LO) begin
            value_in = {8'h00, b};
         end else if (off_ff == attrbt_pkg::OFF_VALUE_HI) begin
            value_in = {b, value_ff[7:0]};
         end else if (off_ff == uuid_off) begin
            uuid_lo_in = b;
         end else if (off_ff == uuid_off + 5'd1) begin
            emit.elem_valid         = 1'b1;
            emit.elem.record_kind   = attrbt_pkg::REC_ELEMENT;
            emit.elem.attr_handle   = start_ff;
            emit.elem.property_bits = prop_ff;
            emit.elem.value_handle  = value_ff;
            emit.elem.short_uuid    = {b, uuid_lo_ff};
            emit.elem.run_end       = !item.last_byte;
            next_handle_in          = start_ff + 16'd1;
            if (done_ff != attrbt_pkg::COUNT_MAX) begin
               done_in = done_ff + 7'd1;
            end
         end
         off_in = (off_next >= size_ff) ? 5'd0 : off_next;
      end

      // Status uses this byte's updated state; a missing header or a byte
      // count that disagrees with the length turns a clean PDU into a length error
      stat_err = err_in;
      if ((err_in == attrbt_pkg::ERR_NONE) &&
          ((size_in == attrbt_pkg::ELEM_SIZE_NONE) ||
           ((11'(pos_ff) + 11'd1) != {1'b0, len}))) begin
         stat_err = attrbt_pkg::ERR_LENGTH;
      end

      if (item.last_byte) begin
         emit.stat_valid         = 1'b1;
         emit.stat.record_kind   = attrbt_pkg::REC_STATUS;
         emit.stat.element_count = done_in;
         emit.stat.next_start    = next_handle_in;
         emit.stat.error_code    = stat_err;
         emit.stat.run_end       = 1'b1;
         pos_in  = 10'd0;
         size_in = attrbt_pkg::ELEM_SIZE_NONE;
         off_in  = 5'd0;
         done_in = 7'd0;
         err_in  = attrbt_pkg::ERR_NONE;
      end else if (pos_ff != attrbt_pkg::POS_MAX) begin
         pos_in = pos_ff + 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         size_ff        <= attrbt_pkg::ELEM_SIZE_NONE;
         off_ff         <= '0;
         done_ff        <= '0;
         err_ff         <= attrbt_pkg::ERR_NONE;
         start_ff       <= '0;
         prop_ff        <= '0;
         value_ff       <= '0;
         uuid_lo_ff     <= '0;
         next_handle_ff <= '0;
      end else if (advance) begin
         pos_ff         <= pos_in;
         size_ff        <= size_in;
         off_ff         <= off_in;
         done_ff        <= done_in;
         err_ff         <= err_in;
         start_ff       <= start_in;
         prop_ff        <= prop_in;
         value_ff       <= value_in;
         uuid_lo_ff     <= uuid_lo_in;
         next_handle_ff <= next_handle_in;
      end
   end

endmodule

// ===== hw/rtl/att_read_by_type_response_parser_core.sv =====
// Top level of the ATT read by type response parser: input register,
// opcode register, parser and result queue. Depends on attrbt_pkg, attrbt_parse.
//
//   channel | dir | handshake               | payload
//   req     | in  | req_valid / req_stall   | req_data (attrbt_pkg::req_type)
//   rsp     | out | rsp_valid / rsp_stall   | rsp_data (attrbt_pkg::rsp_type)
//   csr     | in  | csr_valid / csr_ready   | csr_data (expected opcode)
//
// One byte transaction per cycle while req_stall is low; a byte's results pass the input
// register and the result queue. A last byte that also completes an element gives two
// results, sent one at a time on rsp; the four-entry result queue absorbs that.
// Synchronous reset clears all parser state and sets the opcode to 9.
// req_stall rises only when the queue lacks room for two more results.
`timescale 1ns / 1ps

module att_read_by_type_response_parser_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  attrbt_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output attrbt_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_data
);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam logic [QPTR_W:0] QCOUNT_MAX = (QPTR_W + 1)'(QDEPTH);
   localparam logic [QPTR_W:0] QROOM_TWO  = (QPTR_W + 1)'(QDEPTH - 2);

   logic [7:0]          opcode_ff;
   logic                in_valid_ff, in_valid_in;
   attrbt_pkg::req_type in_data_ff;
   attrbt_pkg::emit_type emit;

   attrbt_pkg::rsp_type q_mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic [QPTR_W-1:0]   stat_ptr;
   logic [1:0]          push_n;

   logic load;
   logic advance;
   logic pop;
   logic push_elem;
   logic push_stat;

   assign csr_ready = 1'b1;

   assign advance   = in_valid_ff && (count_ff <= QROOM_TWO);
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q_mem[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign push_elem = advance && emit.elem_valid;
   assign push_stat = advance && emit.stat_valid;
   assign push_n    = 2'(push_elem) + 2'(push_stat);
   assign stat_ptr  = wr_ptr_ff + QPTR_W'(push_elem);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + (QPTR_W + 1)'(push_n) - (QPTR_W + 1)'(pop);
   end

   attrbt_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .item            (in_data_ff),
      .expected_opcode (opcode_ff),
      .emit            (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff   <= attrbt_pkg::OPCODE_RESET;
         in_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            opcode_ff <= csr_data;
         end
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (push_elem) begin
         q_mem[wr_ptr_ff] <= emit.elem;
      end
      if (push_stat) begin
         q_mem[stat_ptr] <= emit.stat;
      end
   end

`ifndef SYNTH
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCOUNT_MAX)
      else $error("result queue overflow");

   a_status_ends_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.record_kind == attrbt_pkg::REC_STATUS)) |->
      rsp_data.run_end)
      else $error("status record without run_end");

   a_element_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.record_kind == attrbt_pkg::REC_ELEMENT)) |->
      ((rsp_data.error_code == attrbt_pkg::ERR_NONE) &&
       (rsp_data.element_count == 7'd0)))
      else $error("element record carries status fields");

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && (count_ff > QROOM_TWO)))
      else $error("input stalled with room in result queue");
`endif

endmodule
